/* sv/pht_pkg.sv */
// shared types, constants and preset table for the preset hysteresis thermostat
package pht_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_HYSTERESIS   = 3'd0,
    CFG_MIN_VALID    = 3'd1,
    CFG_ABS_MIN      = 3'd2,
    CFG_ABS_MAX      = 3'd3,
    CFG_CONV_GAIN    = 3'd4,
    CFG_CONV_OFFSET  = 3'd5,
    CFG_AUTO_OFF     = 3'd6,
    CFG_READ_INTERVAL = 3'd7
  } cfg_reg_e;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam int AdcW     = 12;
  localparam int DegW     = 8;
  localparam int SlotW    = 3;
  localparam int ConvW    = 24;
  localparam int FracBits = 16;
  // gain times reading plus offset, signed
  localparam int ProdW    = ConvW + AdcW + 1;

  localparam logic [DegW-1:0] TargetStep = 8'd5;
  localparam logic [DegW-1:0] ResetCurDeg = 8'd72;

  // button and tick events of one request
  typedef struct packed {
    logic tick;
    logic prog;
    logic onoff;
    logic minus;
    logic plus;
  } pht_evt_t;

  // fixed preset temperatures, slots past the fourth read the last value
  function automatic logic [DegW-1:0] preset_deg(logic [SlotW-1:0] idx);
    logic [DegW-1:0] deg;
    case (idx)
      3'd0:    deg = 8'd70;
      3'd1:    deg = 8'd75;
      3'd2:    deg = 8'd80;
      3'd3:    deg = 8'd85;
      default: deg = 8'd90;
    endcase
    return deg;
  endfunction

endpackage

/* sv/pht_tick_timer.sv */
// tick counter that fires when it reaches its limit, cleared by a button press
module pht_tick_timer #(
  parameter int CntW = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         clear_i,
  input  logic                         tick_i,
  input  logic [pht_pkg::CfgDataW-1:0] limit_i,
  output logic                         fire_o
);
  import pht_pkg::*;

  localparam int CmpW = (CntW > CfgDataW) ? CntW : CfgDataW;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] base;
  logic [CntW-1:0] inc;

  // press clears first, then a tick counts and may fire
  always_comb begin
    base   = clear_i ? '0 : cnt_q;
    inc    = base + {{(CntW-1){1'b0}}, 1'b1};
    fire_o = 1'b0;
    cnt_d  = base;
    if (tick_i) begin
      if (CmpW'(inc) >= CmpW'(limit_i)) begin
        fire_o = 1'b1;
        cnt_d  = '0;
      end else begin
        cnt_d  = inc;
      end
    end
  end

  // counter updates only when a request completes its pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (en_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

/* sv/preset_hysteresis_thermostat_core.sv */
// top level of the preset hysteresis thermostat control pass
//
//  channel | signals                                      | role
//  --------+----------------------------------------------+---------------------------
//  in      | in_valid_i/in_ready_o, tick..adc_average_i    | one control pass request
//  out     | out_valid_o/out_ready_i, heater_on..slot_o    | state after the pass
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i              | register write, no wait
//
// one request per cycle while the result is not stalled; a request is registered in
// stage one, the conversion multiply feeds stage two, and the
// state update runs as stage two moves into the result register
// a stalled result holds the state; earlier stages keep filling until full
// reset loads the register defaults and the power-up state
module preset_hysteresis_thermostat_core #(
  parameter int PRESET_COUNT      = 6,
  parameter int TICK_COUNTER_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          tick_i,
  input  logic                          prog_pressed_i,
  input  logic                          onoff_pressed_i,
  input  logic                          minus_pressed_i,
  input  logic                          plus_pressed_i,
  input  logic [pht_pkg::AdcW-1:0]      adc_average_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          heater_on_o,
  output logic                          powered_on_o,
  output logic [pht_pkg::DegW-1:0]      target_deg_o,
  output logic [pht_pkg::DegW-1:0]      measured_deg_o,
  output logic [pht_pkg::SlotW-1:0]     preset_slot_o,
  input  logic                          cfg_we_i,
  input  logic [pht_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pht_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import pht_pkg::*;

  localparam logic [SlotW-1:0] LastSlot = SlotW'(PRESET_COUNT - 1);

  // configuration registers
  logic [5:0]              hyst_q;
  logic [6:0]              min_q;
  logic [DegW-1:0]         abs_min_q;
  logic [DegW-1:0]         abs_max_q;
  logic signed [ConvW-1:0] gain_q;
  logic signed [ConvW-1:0] offset_q;
  logic [CfgDataW-1:0]     auto_off_q;
  logic [CfgDataW-1:0]     read_int_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q     <= 6'd5;
      min_q      <= 7'd10;
      abs_min_q  <= 8'd40;
      abs_max_q  <= 8'd100;
      gain_q     <= 24'sd2048;
      offset_q   <= '0;
      auto_off_q <= 32'd300;
      read_int_q <= 32'd2;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_HYSTERESIS:    hyst_q     <= cfg_wdata_i[5:0];
        CFG_MIN_VALID:     min_q      <= cfg_wdata_i[6:0];
        CFG_ABS_MIN:       abs_min_q  <= cfg_wdata_i[DegW-1:0];
        CFG_ABS_MAX:       abs_max_q  <= cfg_wdata_i[DegW-1:0];
        CFG_CONV_GAIN:     gain_q     <= $signed(cfg_wdata_i[ConvW-1:0]);
        CFG_CONV_OFFSET:   offset_q   <= $signed(cfg_wdata_i[ConvW-1:0]);
        CFG_AUTO_OFF:      auto_off_q <= cfg_wdata_i;
        CFG_READ_INTERVAL: read_int_q <= cfg_wdata_i;
        default:           ;
      endcase
    end
  end

  // pipeline handshake
  logic             s1_v_q, s2_v_q, out_v_q;
  logic             rdy_out, rdy2, rdy1;
  logic             adv_out;
  pht_evt_t         s1_evt_q, s2_evt_q;
  logic [AdcW-1:0]  s1_adc_q;
  logic signed [ProdW-1:0] s2_val_q, s2_val_d;

  assign rdy_out    = !out_v_q || out_ready_i;
  assign rdy2       = !s2_v_q || rdy_out;
  assign rdy1       = !s1_v_q || rdy2;
  assign in_ready_o = rdy1;
  assign adv_out    = s2_v_q && rdy_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1) s1_v_q <= in_valid_i;
      if (rdy2) s2_v_q <= s1_v_q;
      if (rdy_out) out_v_q <= s2_v_q;
    end
  end

  // stage one: request register
  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      s1_evt_q <= '{tick: tick_i, prog: prog_pressed_i, onoff: onoff_pressed_i,
                    minus: minus_pressed_i, plus: plus_pressed_i};
      s1_adc_q <= adc_average_i;
    end
  end

  // conversion multiply, fixed point with sixteen fraction bits
  assign s2_val_d = ProdW'(gain_q) * ProdW'($signed({1'b0, s1_adc_q})) + ProdW'(offset_q);

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_v_q) begin
      s2_evt_q <= s1_evt_q;
      s2_val_q <= s2_val_d;
    end
  end

  // reading in whole degrees, clamped below at min valid and saturated
  logic [DegW-1:0]             reading;
  logic                        below_min;
  logic [ProdW-FracBits-1:0]   whole;
  logic                        invalid;

  always_comb begin
    below_min = s2_val_q < $signed({{(ProdW-7-FracBits){1'b0}}, min_q, {FracBits{1'b0}}});
    whole     = s2_val_q[ProdW-1:FracBits];
    if (below_min) begin
      reading = {1'b0, min_q};
    end else if (|whole[ProdW-FracBits-1:DegW]) begin
      reading = '1;
    end else begin
      reading = whole[DegW-1:0];
    end
    invalid = reading <= {1'b0, min_q};
  end

  // tick timers
  logic any_press;
  logic off_fire, read_fire;

  assign any_press = s2_evt_q.prog || s2_evt_q.onoff || s2_evt_q.minus || s2_evt_q.plus;

  pht_tick_timer #(
    .CntW (TICK_COUNTER_BITS)
  ) u_auto_off (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv_out),
    .clear_i (any_press),
    .tick_i  (s2_evt_q.tick),
    .limit_i (auto_off_q),
    .fire_o  (off_fire)
  );

  pht_tick_timer #(
    .CntW (TICK_COUNTER_BITS)
  ) u_read_int (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv_out),
    .clear_i (1'b0),
    .tick_i  (s2_evt_q.tick),
    .limit_i (read_int_q),
    .fire_o  (read_fire)
  );

  // controller state, which is also the result register
  logic             on_q, on_d;
  logic             heat_q, heat_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [DegW-1:0]  tgt_q, tgt_d;
  logic [DegW-1:0]  cur_q, cur_d;
  logic signed [DegW+1:0] step_val;
  logic signed [DegW+1:0] heat_lim;

  // buttons in order program, on/off, minus, plus; then timers, reading, hysteresis
  always_comb begin
    on_d   = on_q;
    slot_d = slot_q;
    tgt_d  = tgt_q;
    cur_d  = cur_q;
    heat_d = heat_q;
    step_val = '0;
    heat_lim = '0;

    if (s2_evt_q.prog) begin
      if (on_d) begin
        slot_d = (slot_d >= LastSlot) ? '0 : slot_d + 3'd1;
      end
      on_d  = 1'b1;
      tgt_d = preset_deg(slot_d);
    end

    if (s2_evt_q.onoff) begin
      if (on_d) begin
        on_d   = 1'b0;
        slot_d = '0;
        tgt_d  = preset_deg('0);
      end else begin
        on_d = 1'b1;
      end
    end

    if (s2_evt_q.minus) begin
      step_val = $signed({2'b0, tgt_d}) - $signed({2'b0, TargetStep});
      if (step_val < $signed({2'b0, abs_min_q})) begin
        tgt_d = abs_min_q;
      end else if (step_val > $signed({2'b0, abs_max_q})) begin
        tgt_d = abs_max_q;
      end else begin
        tgt_d = step_val[DegW-1:0];
      end
    end

    if (s2_evt_q.plus) begin
      step_val = $signed({2'b0, tgt_d}) + $signed({2'b0, TargetStep});
      if (step_val < $signed({2'b0, abs_min_q})) begin
        tgt_d = abs_min_q;
      end else if (step_val > $signed({2'b0, abs_max_q})) begin
        tgt_d = abs_max_q;
      end else begin
        tgt_d = step_val[DegW-1:0];
      end
    end

    if (off_fire || invalid) begin
      on_d   = 1'b0;
      slot_d = '0;
      tgt_d  = preset_deg('0);
    end

    if (read_fire) begin
      cur_d = reading;
    end

    heat_lim = $signed({2'b0, tgt_d}) - $signed({4'b0, hyst_q});
    if (!on_d) begin
      heat_d = 1'b0;
    end else begin
      if (cur_d > tgt_d) heat_d = 1'b0;
      if ($signed({2'b0, cur_d}) < heat_lim) heat_d = 1'b1;
      if (cur_d <= {1'b0, min_q}) heat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q   <= 1'b0;
      heat_q <= 1'b0;
      slot_q <= '0;
      tgt_q  <= preset_deg('0);
      cur_q  <= ResetCurDeg;
    end else if (adv_out) begin
      on_q   <= on_d;
      heat_q <= heat_d;
      slot_q <= slot_d;
      tgt_q  <= tgt_d;
      cur_q  <= cur_d;
    end
  end

  // result ports
  assign out_valid_o    = out_v_q;
  assign heater_on_o    = heat_q;
  assign powered_on_o   = on_q;
  assign target_deg_o   = tgt_q;
  assign measured_deg_o = cur_q;
  assign preset_slot_o  = slot_q;

endmodule

/* sv/pht_checker.sv */
// port level checks for the thermostat core, bound to the top level
module pht_checker #(
  parameter int PRESET_COUNT = 6
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic                     heater_on_o,
  input logic                     powered_on_o,
  input logic [pht_pkg::DegW-1:0] target_deg_o,
  input logic [pht_pkg::DegW-1:0] measured_deg_o,
  input logic [pht_pkg::SlotW-1:0] preset_slot_o
);
  import pht_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(heater_on_o) &&
      $stable(powered_on_o) && $stable(target_deg_o) && $stable(measured_deg_o) &&
      $stable(preset_slot_o))
    else $error("result changed while stalled");

  // heater never drives while the unit is off
  a_off_no_heat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !powered_on_o |-> !heater_on_o)
    else $error("heater on while unit off");

  // switching off always returns to the first preset
  a_off_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !powered_on_o |-> preset_slot_o == '0)
    else $error("preset slot not cleared while off");

  // preset slot stays inside the table
  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> int'(preset_slot_o) < PRESET_COUNT)
    else $error("preset slot out of range");

endmodule

bind preset_hysteresis_thermostat_core pht_checker #(
  .PRESET_COUNT (PRESET_COUNT)
) u_pht_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .heater_on_o    (heater_on_o),
  .powered_on_o   (powered_on_o),
  .target_deg_o   (target_deg_o),
  .measured_deg_o (measured_deg_o),
  .preset_slot_o  (preset_slot_o)
);
